// ===== src/bnh_pkg.sv =====
// Shared types, codes and saturation helper for the bivariate Newton-Horner evaluator.
`default_nettype none

package bnh_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * WORD_W;
    localparam int WIDE_W = PROD_W - FRAC_W + 1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_WR_COEF  = 2'd0;
    localparam t_mode MODE_WR_XKNOT = 2'd1;
    localparam t_mode MODE_WR_YKNOT = 2'd2;
    localparam t_mode MODE_EVAL     = 2'd3;

    localparam logic [3:0] TERMS_RESET = 4'd8;

    typedef struct packed {
        logic  sat;
        t_word value;
    } t_sat_word;

    typedef struct packed {
        logic load_diff;
        logic load_prod;
    } t_nest_ctrl;

    // Clamp a wide signed value to the word range and flag the clamp.
    function automatic t_sat_word sat_word(input t_wide v);
        t_sat_word r;
        logic [WIDE_W-WORD_W:0] hi;
        hi = v[WIDE_W-1:WORD_W-1];
        r.sat = !((&hi) || !(|hi));
        if (!r.sat) begin
            r.value = v[WORD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r.value = t_word'({1'b1, {(WORD_W-1){1'b0}}});
        end else begin
            r.value = t_word'({1'b0, {(WORD_W-1){1'b1}}});
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/bnh_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module bnh_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/bnh_nest_unit.sv =====
// One Horner nesting step: saturated difference, registered product, shift, add, saturate.
`default_nettype none

module bnh_nest_unit
    import bnh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_nest_ctrl i_ctrl,
    input  wire t_word      i_point,
    input  wire t_word      i_knot,
    input  wire t_word      i_coef,
    input  wire t_word      i_acc,
    output logic            o_diff_sat,
    output t_sat_word       o_sum
);

    t_sat_word w_diff;
    t_word     r_diff;
    t_word     r_coef;
    t_prod     r_prod;

    assign w_diff     = sat_word(t_wide'(i_point) - t_wide'(i_knot));
    assign o_diff_sat = w_diff.sat;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_diff) begin
            r_diff <= w_diff.value;
            r_coef <= i_coef;
        end
        if (i_ctrl.load_prod) begin
            r_prod <= t_prod'(i_acc) * t_prod'(r_diff);
        end
    end

    // arithmetic shift floors toward minus infinity
    assign o_sum = sat_word(t_wide'(signed'(r_prod[PROD_W-1:FRAC_W])) + t_wide'(r_coef));

endmodule

`default_nettype wire

// ===== src/bivariate_newton_horner_eval_unit.sv =====
// Top level of the bivariate Newton-form polynomial evaluator with its sequencer.
//
// The block keeps an n-by-n Q16.16 coefficient table and two knot vectors in
// three single-port RAMs and evaluates the tensor-product Newton form at a
// point (x,y). Mode 0 writes coefficient (row, col), mode 1 writes x knot row,
// mode 2 writes y knot row; a write with an index not below MAX_TERMS is
// dropped, and writes give no result. Mode 3 evaluates: columns are walked
// from the last to the first, each reduced by Horner nesting over the x knots,
// and each finished column is folded at once into a second Horner chain over
// the y knots, so no column values are stored. Every nesting step computes
// sat(((acc * sat(p - k)) >>> 16) + c); the saturated output flags any clamp
// in that evaluation. Writes finish in the accepting cycle. An evaluation
// holds the input stalled from acceptance until the result register is
// loaded: each nesting step runs through the states READ (RAM read), DIFF
// (difference), MUL (multiply) and ADD (shift-add-saturate) on the one
// shared multiply-add unit, the seed of each column through READ and DIFF,
// and the hand-over to the result register is made from OUT once free. The
// result waits in an output register, so a new item is taken while it is
// still stalled. terms_in_use of 0 acts as 1 and values above MAX_TERMS act
// as MAX_TERMS; it must only be written while the block is idle.
`default_nettype none

module bivariate_newton_horner_eval_unit
    import bnh_pkg::*;
#(
    parameter int MAX_TERMS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [2:0]  i_row_index,
    input  wire logic [2:0]  i_col_index,
    input  wire t_word       i_write_value,
    input  wire t_word       i_point_x,
    input  wire t_word       i_point_y,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_word            o_poly_value,
    output logic             o_saturated
);

    localparam int KW       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int C_DEPTH  = MAX_TERMS * MAX_TERMS;
    localparam int CW       = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
    localparam int RST_TERMS = (int'(TERMS_RESET) > MAX_TERMS) ? MAX_TERMS
                                                               : int'(TERMS_RESET);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // control state
    logic [2:0]    r_state, n_state;
    logic [KW-1:0] r_nm1, n_nm1;
    logic          r_out_valid, n_out_valid;
    // sequencer and payload
    logic [KW-1:0] r_row, n_row;
    logic [KW-1:0] r_col, n_col;
    logic          r_ypass, n_ypass;
    logic          r_flag, n_flag;
    t_word         r_acc, n_acc;
    t_word         r_yacc, n_yacc;
    t_word         r_px, n_px;
    t_word         r_py, n_py;
    t_word         r_out_value, n_out_value;
    logic          r_out_sat, n_out_sat;

    logic          w_accept;
    logic          w_row_ok;
    logic          w_col_ok;
    logic [CW-1:0] w_coeff_addr;
    logic [KW-1:0] w_xk_addr;
    logic [KW-1:0] w_yk_addr;
    logic [WORD_W-1:0] w_coeff_rdata;
    logic [WORD_W-1:0] w_xk_rdata;
    logic [WORD_W-1:0] w_yk_rdata;
    logic          w_seed;
    logic          w_step_done;
    t_word         w_new;
    logic          w_diff_sat;
    t_sat_word     w_sum;
    t_nest_ctrl    w_ctrl;
    logic [KW-1:0] w_cfg_nm1;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_row_ok   = int'(i_row_index) < MAX_TERMS;
    assign w_col_ok   = int'(i_col_index) < MAX_TERMS;

    // writes address the RAMs while idle, the sequencer while busy
    assign w_coeff_addr = (r_state == ST_IDLE)
        ? CW'(int'(i_row_index) * MAX_TERMS + int'(i_col_index))
        : CW'(int'(r_row) * MAX_TERMS + int'(r_col));
    assign w_xk_addr = (r_state == ST_IDLE) ? KW'(i_row_index) : r_row;
    assign w_yk_addr = (r_state == ST_IDLE) ? KW'(i_row_index) : r_col;

    bnh_ram #(.WIDTH(WORD_W), .DEPTH(C_DEPTH)) u_coeff_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_mode == MODE_WR_COEF && w_row_ok && w_col_ok),
        .i_addr  (w_coeff_addr),
        .i_wdata (i_write_value),
        .o_rdata (w_coeff_rdata)
    );

    bnh_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TERMS)) u_xknot_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_mode == MODE_WR_XKNOT && w_row_ok),
        .i_addr  (w_xk_addr),
        .i_wdata (i_write_value),
        .o_rdata (w_xk_rdata)
    );

    bnh_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TERMS)) u_yknot_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_mode == MODE_WR_YKNOT && w_row_ok),
        .i_addr  (w_yk_addr),
        .i_wdata (i_write_value),
        .o_rdata (w_yk_rdata)
    );

    // The x chain seeds from the top coefficient; the y step folds the
    // finished column value (held in r_acc) into the running y value.
    assign w_seed = (r_state == ST_DIFF) && !r_ypass && (r_row == r_nm1);
    assign w_ctrl.load_diff = (r_state == ST_DIFF) && !w_seed;
    assign w_ctrl.load_prod = (r_state == ST_MUL);

    bnh_nest_unit u_nest (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_point    (r_ypass ? r_py : r_px),
        .i_knot     (r_ypass ? t_word'(w_yk_rdata) : t_word'(w_xk_rdata)),
        .i_coef     (r_ypass ? r_acc : t_word'(w_coeff_rdata)),
        .i_acc      (r_ypass ? r_yacc : r_acc),
        .o_diff_sat (w_diff_sat),
        .o_sum      (w_sum)
    );

    assign w_step_done = w_seed || (r_state == ST_ADD);
    assign w_new       = w_seed ? t_word'(w_coeff_rdata) : w_sum.value;

    // clamp the term count at write time
    always_comb begin
        if (i_cfg_wdata == 4'd0) begin
            w_cfg_nm1 = '0;
        end else if (int'(i_cfg_wdata) > MAX_TERMS) begin
            w_cfg_nm1 = KW'(MAX_TERMS - 1);
        end else begin
            w_cfg_nm1 = KW'(int'(i_cfg_wdata) - 1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_nm1       = i_cfg_we ? w_cfg_nm1 : r_nm1;
        n_out_valid = r_out_valid && i_out_stall;
        n_row       = r_row;
        n_col       = r_col;
        n_ypass     = r_ypass;
        n_flag      = r_flag;
        n_acc       = r_acc;
        n_yacc      = r_yacc;
        n_px        = r_px;
        n_py        = r_py;
        n_out_value = r_out_value;
        n_out_sat   = r_out_sat;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_mode == MODE_EVAL) begin
                    n_px    = i_point_x;
                    n_py    = i_point_y;
                    n_row   = r_nm1;
                    n_col   = r_nm1;
                    n_ypass = 1'b0;
                    n_flag  = 1'b0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                if (!w_seed) begin
                    n_flag  = r_flag || w_diff_sat;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_flag = r_flag || w_sum.sat;
            end
            ST_OUT: begin
                // hand over once the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_yacc;
                    n_out_sat   = r_flag;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // advance the walk after a seed or a finished nesting step
        if (w_step_done) begin
            if (r_ypass) begin
                n_yacc  = w_new;
                n_ypass = 1'b0;
                if (r_col == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_col   = r_col - 1'b1;
                    n_row   = r_nm1;
                    n_state = ST_READ;
                end
            end else begin
                n_acc = w_new;
                if (r_row != '0) begin
                    n_row   = r_row - 1'b1;
                    n_state = ST_READ;
                end else if (r_col != r_nm1) begin
                    n_ypass = 1'b1;
                    n_state = ST_READ;
                end else begin
                    // first column seeds the y chain
                    n_yacc = w_new;
                    if (r_col == '0) begin
                        n_state = ST_OUT;
                    end else begin
                        n_col   = r_col - 1'b1;
                        n_row   = r_nm1;
                        n_state = ST_READ;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nm1       <= KW'(RST_TERMS - 1);
            r_out_valid <= 1'b0;
            r_ypass     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nm1       <= n_nm1;
            r_out_valid <= n_out_valid;
            r_ypass     <= n_ypass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_col       <= n_col;
        r_flag      <= n_flag;
        r_acc       <= n_acc;
        r_yacc      <= n_yacc;
        r_px        <= n_px;
        r_py        <= n_py;
        r_out_value <= n_out_value;
        r_out_sat   <= n_out_sat;
    end

    assign o_out_valid  = r_out_valid;
    assign o_poly_value = r_out_value;
    assign o_saturated  = r_out_sat;

`ifndef NO_ASSERTIONS
    // a result appears only from the hand-over state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result loaded outside hand-over");

    // a free result register takes the finished value at once
    a_out_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !o_out_valid) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished value not handed over");

    // the y step never spans idle or hand-over
    a_ypass_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ypass |-> (r_state != ST_IDLE && r_state != ST_OUT))
        else $error("y step flag left set");
`endif

endmodule

`default_nettype wire
